/* src/assert_macros.svh */
// Assertion macros shared by the spanning tree RTL.
// Bodies compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* src/mstp_pkg.sv */
// Shared constants, codes and control types of the spanning tree block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mstp_pkg;

   localparam int MAX_VERTICES = 64;
   localparam int WEIGHT_BITS  = 32;

   localparam int VTX_W      = $clog2(MAX_VERTICES);
   localparam int CNT_W      = $clog2(MAX_VERTICES + 1);
   localparam int ADDR_W     = $clog2(MAX_VERTICES * MAX_VERTICES);
   localparam int PORT_VTX_W = 6;
   localparam int PORT_WT_W  = 32;
   localparam int CMP_W      = (WEIGHT_BITS > PORT_WT_W) ? WEIGHT_BITS : PORT_WT_W;
   localparam int VCOUNT_W   = 7;
   localparam int COST_W     = 38;
   localparam int CSR_IDX_W  = 1;

   localparam logic [COST_W-1:0]    COST_MAX     = '1;
   localparam logic [VCOUNT_W-1:0]  VCOUNT_RESET = 7'd64;
   localparam logic [PORT_WT_W-1:0] INF_RESET    = 32'd256000000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VERTEX_COUNT = 1'b0,
      CSR_INFINITY     = 1'b1
   } csr_index_type;

   typedef enum logic {
      REQ_WRITE = 1'b0,
      REQ_RUN   = 1'b1
   } req_kind_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CHECK = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_DRAIN = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   typedef struct packed {
      logic write_entry;
      logic load_run;
      logic set_start;
      logic begin_scan;
      logic scan_step;
      logic emit_edge;
      logic emit_bad;
   } cmd_type;

   typedef struct packed {
      logic start_bad;
      logic single;
      logic scan_end;
      logic found;
      logic run_last;
   } status_type;

endpackage
`default_nettype wire

/* src/mstp_ctrl.sv */
// Sequencer of the spanning tree block: run setup, scan, drain and emit.
// Depends on mstp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mstp_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic                 req_type,
   input  wire mstp_pkg::status_type sts,
   output mstp_pkg::cmd_type         cmd,
   output logic                      busy
);

   mstp_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mstp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         mstp_pkg::ST_IDLE: begin
            if (start) begin
               if (req_type == mstp_pkg::REQ_RUN) begin
                  cmd.load_run = 1'b1;
                  state_in     = mstp_pkg::ST_CHECK;
               end else begin
                  cmd.write_entry = 1'b1;
               end
            end
         end
         mstp_pkg::ST_CHECK: begin
            if (sts.start_bad) begin
               cmd.emit_bad = 1'b1;
               state_in     = mstp_pkg::ST_IDLE;
            end else if (sts.single) begin
               state_in = mstp_pkg::ST_IDLE;
            end else begin
               cmd.set_start  = 1'b1;
               cmd.begin_scan = 1'b1;
               state_in       = mstp_pkg::ST_SCAN;
            end
         end
         mstp_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_end) begin
               state_in = mstp_pkg::ST_DRAIN;
            end
         end
         mstp_pkg::ST_DRAIN: begin
            state_in = mstp_pkg::ST_EMIT;
         end
         mstp_pkg::ST_EMIT: begin
            cmd.emit_edge = 1'b1;
            if (!sts.found || sts.run_last) begin
               state_in = mstp_pkg::ST_IDLE;
            end else begin
               cmd.begin_scan = 1'b1;
               state_in       = mstp_pkg::ST_SCAN;
            end
         end
         default: begin
            state_in = mstp_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != mstp_pkg::ST_IDLE);

endmodule
`default_nettype wire

/* src/mstp_dp.sv */
// Datapath of the spanning tree block: weight memory, tree flags, minimum
// search, cost accumulation, config registers and result word. Uses mstp_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module mstp_dp (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire mstp_pkg::cmd_type                    cmd,
   output mstp_pkg::status_type                      sts,
   input  wire logic [mstp_pkg::PORT_VTX_W-1:0]      req_row_vertex,
   input  wire logic [mstp_pkg::PORT_VTX_W-1:0]      req_col_vertex,
   input  wire logic [mstp_pkg::PORT_WT_W-1:0]       req_edge_weight_in,
   input  wire logic [mstp_pkg::PORT_VTX_W-1:0]      req_start_vertex,
   input  wire logic                                 csr_write,
   input  wire logic [mstp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [mstp_pkg::PORT_WT_W-1:0]       csr_data,
   output logic                                      rsp_valid,
   output logic [mstp_pkg::PORT_VTX_W-1:0]           rsp_from_vertex,
   output logic [mstp_pkg::PORT_VTX_W-1:0]           rsp_to_vertex,
   output logic [mstp_pkg::PORT_WT_W-1:0]            rsp_edge_weight_out,
   output logic [mstp_pkg::COST_W-1:0]               rsp_total_cost,
   output logic                                      rsp_last,
   output logic                                      rsp_status
);

   logic [mstp_pkg::WEIGHT_BITS-1:0] mem [mstp_pkg::MAX_VERTICES*mstp_pkg::MAX_VERTICES];

   logic [mstp_pkg::VCOUNT_W-1:0]    vcount_ff;
   logic [mstp_pkg::PORT_WT_W-1:0]   inf_ff;
   logic [mstp_pkg::CNT_W-1:0]       n_ff, n_in;
   logic [mstp_pkg::PORT_VTX_W-1:0]  s_ff;
   logic [mstp_pkg::MAX_VERTICES-1:0] tree_ff;
   logic [mstp_pkg::VTX_W-1:0]       u_ff, v_ff;
   logic [mstp_pkg::VTX_W-1:0]       cand_u_ff, cand_v_ff;
   logic                             qual_ff;
   logic [mstp_pkg::WEIGHT_BITS-1:0] rd_data_ff;
   logic [mstp_pkg::CMP_W-1:0]       cmin_ff;
   logic [mstp_pkg::VTX_W-1:0]       bu_ff, bv_ff;
   logic                             found_ff;
   logic [mstp_pkg::COST_W-1:0]      cost_ff, cost_in, cmin_cost;
   logic [mstp_pkg::CNT_W-1:0]       edges_ff;
   logic [mstp_pkg::VTX_W-1:0]       nm1;
   logic [mstp_pkg::ADDR_W-1:0]      wr_addr, rd_addr;
   logic                             wr_ok;
   logic [mstp_pkg::CMP_W-1:0]       rd_ext;

   logic                                 rsp_valid_ff;
   logic [mstp_pkg::PORT_VTX_W-1:0]      rsp_from_ff, rsp_to_ff;
   logic [mstp_pkg::PORT_WT_W-1:0]       rsp_wt_ff;
   logic [mstp_pkg::COST_W-1:0]          rsp_cost_ff;
   logic                                 rsp_last_ff, rsp_status_ff;

   // weight memory
   assign wr_ok = (mstp_pkg::CNT_W'(req_row_vertex) < mstp_pkg::CNT_W'(mstp_pkg::MAX_VERTICES))
               && (mstp_pkg::CNT_W'(req_col_vertex) < mstp_pkg::CNT_W'(mstp_pkg::MAX_VERTICES));
   assign wr_addr = mstp_pkg::ADDR_W'(
      mstp_pkg::ADDR_W'(req_row_vertex) * mstp_pkg::ADDR_W'(mstp_pkg::MAX_VERTICES)
      + mstp_pkg::ADDR_W'(req_col_vertex));
   assign rd_addr = mstp_pkg::ADDR_W'(
      mstp_pkg::ADDR_W'(u_ff) * mstp_pkg::ADDR_W'(mstp_pkg::MAX_VERTICES)
      + mstp_pkg::ADDR_W'(v_ff));

   always_ff @(posedge clock) begin
      if (cmd.write_entry && wr_ok) begin
         mem[wr_addr] <= mstp_pkg::WEIGHT_BITS'(req_edge_weight_in);
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= mstp_pkg::VCOUNT_RESET;
         inf_ff    <= mstp_pkg::INF_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            mstp_pkg::CSR_VERTEX_COUNT: vcount_ff <= mstp_pkg::VCOUNT_W'(csr_data);
            mstp_pkg::CSR_INFINITY:     inf_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // clamp vertex count into 1..MAX_VERTICES
   always_comb begin
      if (vcount_ff == '0) begin
         n_in = mstp_pkg::CNT_W'(1);
      end else if (mstp_pkg::CNT_W'(vcount_ff) > mstp_pkg::CNT_W'(mstp_pkg::MAX_VERTICES)) begin
         n_in = mstp_pkg::CNT_W'(mstp_pkg::MAX_VERTICES);
      end else begin
         n_in = mstp_pkg::CNT_W'(vcount_ff);
      end
   end

   assign nm1          = mstp_pkg::VTX_W'(n_ff - mstp_pkg::CNT_W'(1));
   assign rd_ext       = mstp_pkg::CMP_W'(rd_data_ff);
   assign cmin_cost    = mstp_pkg::COST_W'(cmin_ff);
   assign cost_in      = (cmin_cost >= mstp_pkg::COST_MAX - cost_ff) ? mstp_pkg::COST_MAX
                                                                    : cost_ff + cmin_cost;

   assign sts.start_bad = (mstp_pkg::CNT_W'(s_ff) >= n_ff);
   assign sts.single    = (n_ff == mstp_pkg::CNT_W'(1));
   assign sts.scan_end  = (u_ff == nm1) && (v_ff == nm1);
   assign sts.found     = found_ff;
   assign sts.run_last  = (edges_ff == n_ff - mstp_pkg::CNT_W'(2));

   // run setup and scan counters
   always_ff @(posedge clock) begin
      if (cmd.load_run) begin
         n_ff <= n_in;
         s_ff <= req_start_vertex;
      end
      if (cmd.begin_scan) begin
         u_ff <= '0;
         v_ff <= '0;
      end else if (cmd.scan_step) begin
         if (v_ff == nm1) begin
            v_ff <= '0;
            u_ff <= u_ff + mstp_pkg::VTX_W'(1);
         end else begin
            v_ff <= v_ff + mstp_pkg::VTX_W'(1);
         end
      end
      cand_u_ff <= u_ff;
      cand_v_ff <= v_ff;
   end

   // tree flags, cost, edge count
   always_ff @(posedge clock) begin
      if (reset) begin
         tree_ff  <= '0;
         cost_ff  <= '0;
         edges_ff <= '0;
         qual_ff  <= 1'b0;
      end else begin
         qual_ff <= cmd.scan_step && tree_ff[u_ff] && !tree_ff[v_ff];
         if (cmd.load_run) begin
            tree_ff  <= '0;
            cost_ff  <= '0;
            edges_ff <= '0;
         end else if (cmd.set_start) begin
            tree_ff[mstp_pkg::VTX_W'(s_ff)] <= 1'b1;
         end else if (cmd.emit_edge && found_ff) begin
            tree_ff[bv_ff] <= 1'b1;
            cost_ff        <= cost_in;
            edges_ff       <= edges_ff + mstp_pkg::CNT_W'(1);
         end
      end
   end

   // running minimum, ties go to the later pair
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (cmd.begin_scan) begin
         found_ff <= 1'b0;
      end else if (qual_ff && rd_ext <= cmin_ff) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.begin_scan) begin
         cmin_ff <= mstp_pkg::CMP_W'(inf_ff);
         bu_ff   <= '0;
         bv_ff   <= '0;
      end else if (qual_ff && rd_ext <= cmin_ff) begin
         cmin_ff <= rd_ext;
         bu_ff   <= cand_u_ff;
         bv_ff   <= cand_v_ff;
      end
   end

   // result word
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit_edge || cmd.emit_bad;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_bad) begin
         rsp_from_ff   <= '0;
         rsp_to_ff     <= '0;
         rsp_wt_ff     <= '0;
         rsp_cost_ff   <= '0;
         rsp_last_ff   <= 1'b1;
         rsp_status_ff <= 1'b1;
      end else if (cmd.emit_edge) begin
         if (found_ff) begin
            rsp_from_ff   <= mstp_pkg::PORT_VTX_W'(bu_ff);
            rsp_to_ff     <= mstp_pkg::PORT_VTX_W'(bv_ff);
            rsp_wt_ff     <= mstp_pkg::PORT_WT_W'(cmin_ff);
            rsp_cost_ff   <= cost_in;
            rsp_last_ff   <= sts.run_last;
            rsp_status_ff <= 1'b0;
         end else begin
            rsp_from_ff   <= '0;
            rsp_to_ff     <= '0;
            rsp_wt_ff     <= '0;
            rsp_cost_ff   <= cost_ff;
            rsp_last_ff   <= 1'b1;
            rsp_status_ff <= 1'b1;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_from_vertex     = rsp_from_ff;
   assign rsp_to_vertex       = rsp_to_ff;
   assign rsp_edge_weight_out = rsp_wt_ff;
   assign rsp_total_cost      = rsp_cost_ff;
   assign rsp_last            = rsp_last_ff;
   assign rsp_status          = rsp_status_ff;

   `ASSERT_NEXT(a_no_back_to_back_word, clock, reset, rsp_valid_ff, !rsp_valid_ff)
   `ASSERT_IMPLIES(a_fail_ends_run, clock, reset, rsp_valid_ff && rsp_status_ff, rsp_last_ff)
   `ASSERT_IMPLIES(a_cost_covers_edge, clock, reset, rsp_valid_ff && !rsp_status_ff, rsp_cost_ff >= mstp_pkg::COST_W'(rsp_wt_ff))
   `ASSERT_NEXT(a_tree_grows_by_one, clock, reset, cmd.emit_edge && found_ff, $countones(tree_ff) == $past($countones(tree_ff)) + 1)

endmodule
`default_nettype wire

/* src/minimum_spanning_tree_prim_top.sv */
// Write items may follow back to back; busy stays low.
// A run holds busy high: a check step, then per edge a scan of all n*n pairs
// from the single weight memory read port, a drain and an emit; a word is strobed on
// rsp_valid for one cycle at the end of each edge, n = vertex_count in use.
// Synchronous active-high reset clears control, tree flags, cost and config
// (vertex_count 64, infinity 256000000); the weight memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module minimum_spanning_tree_prim_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic                              req_type,
   input  wire logic [mstp_pkg::PORT_VTX_W-1:0]   req_row_vertex,
   input  wire logic [mstp_pkg::PORT_VTX_W-1:0]   req_col_vertex,
   input  wire logic [mstp_pkg::PORT_WT_W-1:0]    req_edge_weight_in,
   input  wire logic [mstp_pkg::PORT_VTX_W-1:0]   req_start_vertex,
   output logic                                   rsp_valid,
   output logic [mstp_pkg::PORT_VTX_W-1:0]        rsp_from_vertex,
   output logic [mstp_pkg::PORT_VTX_W-1:0]        rsp_to_vertex,
   output logic [mstp_pkg::PORT_WT_W-1:0]         rsp_edge_weight_out,
   output logic [mstp_pkg::COST_W-1:0]            rsp_total_cost,
   output logic                                   rsp_last,
   output logic                                   rsp_status,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [mstp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [mstp_pkg::PORT_WT_W-1:0]    csr_data
);

   mstp_pkg::cmd_type    cmd;
   mstp_pkg::status_type sts;

   assign csr_ready = 1'b1;

   mstp_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_type),
      .sts      (sts),
      .cmd      (cmd),
      .busy     (busy)
   );

   mstp_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_row_vertex      (req_row_vertex),
      .req_col_vertex      (req_col_vertex),
      .req_edge_weight_in  (req_edge_weight_in),
      .req_start_vertex    (req_start_vertex),
      .csr_write           (csr_valid && csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .rsp_valid           (rsp_valid),
      .rsp_from_vertex     (rsp_from_vertex),
      .rsp_to_vertex       (rsp_to_vertex),
      .rsp_edge_weight_out (rsp_edge_weight_out),
      .rsp_total_cost      (rsp_total_cost),
      .rsp_last            (rsp_last),
      .rsp_status          (rsp_status)
   );

endmodule
`default_nettype wire
